// File: design/otrw_pkg.sv
// Shared types and constants of the owner-tracking reader-writer lock.
package otrw_pkg;

   localparam int unsigned MAX_READERS_DEF    = 16;
   localparam int unsigned THREAD_ID_BITS_DEF = 8;
   localparam int unsigned ID_FIELD_BITS      = 8;
   localparam int unsigned ANSWER_BITS        = 3;
   localparam int unsigned REQ_TDATA_BITS     = 16;
   localparam int unsigned RSP_TDATA_BITS     = 8;

   typedef enum logic [1:0] {
      CMD_QUERY   = 2'd0,
      CMD_LOCK    = 2'd1,
      CMD_UNLOCK  = 2'd2,
      CMD_INVALID = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   localparam logic [ANSWER_BITS-1:0] QRY_UNLOCKED  = 3'd0;
   localparam logic [ANSWER_BITS-1:0] QRY_WR_MINE   = 3'd1;
   localparam logic [ANSWER_BITS-1:0] QRY_WR_OTHER  = 3'd2;
   localparam logic [ANSWER_BITS-1:0] QRY_RD_MINE   = 3'd3;
   localparam logic [ANSWER_BITS-1:0] QRY_RD_OTHERS = 3'd4;

   localparam logic [ANSWER_BITS-1:0] LOCK_REFUSED  = 3'd0;
   localparam logic [ANSWER_BITS-1:0] LOCK_GRANTED  = 3'd1;

   localparam logic [ANSWER_BITS-1:0] UNL_NOT_HELD  = 3'd0;
   localparam logic [ANSWER_BITS-1:0] UNL_RELEASED  = 3'd1;
   localparam logic [ANSWER_BITS-1:0] UNL_WR_OTHER  = 3'd2;

   typedef struct packed {
      logic [ANSWER_BITS-1:0] answer;
      logic                   bad_command;
   } result_type;

endpackage

// File: design/otrw_id_ram.sv
// Reader ID store: one write port, one registered read port.
module otrw_id_ram #(
   parameter int unsigned DEPTH = otrw_pkg::MAX_READERS_DEF,
   parameter int unsigned WIDTH = otrw_pkg::ID_FIELD_BITS
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/otrw_ctrl.sv
// Lock sequencer: lock state, reader list scan and compaction over the ID store.
module otrw_ctrl #(
   parameter int unsigned MAX_READERS    = otrw_pkg::MAX_READERS_DEF,
   parameter int unsigned THREAD_ID_BITS = otrw_pkg::THREAD_ID_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [1:0]                               command,
   input  logic [otrw_pkg::ID_FIELD_BITS-1:0]       thread_id,
   input  logic                                     read_only,
   input  logic                                     out_free,
   output logic                                     idle,
   output logic                                     done,
   output otrw_pkg::result_type                     result
);

   localparam int unsigned IdW  = (THREAD_ID_BITS < otrw_pkg::ID_FIELD_BITS) ?
                                  THREAD_ID_BITS : otrw_pkg::ID_FIELD_BITS;
   localparam int unsigned IdxW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int unsigned CntW = $clog2(MAX_READERS + 1);

   otrw_pkg::state_type   state_ff, state_in;
   otrw_pkg::command_type cmd_ff, cmd_in;
   logic [IdW-1:0]        id_ff, id_in;
   logic                  rd_ff, rd_in;
   logic                  write_held_ff, write_held_in;
   logic [IdW-1:0]        writer_id_ff, writer_id_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [CntW-1:0]       addr_ff, addr_in;
   logic                  pend_ff, pend_in;
   logic [CntW-1:0]       pend_addr_ff, pend_addr_in;
   logic [otrw_pkg::ANSWER_BITS-1:0] answer_ff, answer_in;
   logic                  bad_ff, bad_in;

   logic                  ram_wr_en;
   logic [IdxW-1:0]       ram_wr_addr;
   logic [IdW-1:0]        ram_wr_data;
   logic                  ram_rd_en;
   logic [IdW-1:0]        ram_rd_data;
   logic [CntW-1:0]       shift_dst;

   logic                  writer_match;
   logic                  count_zero;
   logic                  count_one;
   logic                  count_full;
   logic                  hit;
   logic                  scan_end;
   logic                  scan_miss;
   logic                  issue;
   logic                  go_scan;

   otrw_id_ram #(
      .DEPTH (MAX_READERS),
      .WIDTH (IdW)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff[IdxW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign writer_match = (writer_id_ff == id_ff);
   assign count_zero   = (count_ff == '0);
   assign count_one    = (count_ff == CntW'(1));
   assign count_full   = (count_ff >= CntW'(MAX_READERS));
   assign hit          = pend_ff && (ram_rd_data == id_ff);
   assign scan_end     = (addr_ff >= count_ff);
   assign scan_miss    = scan_end && !hit;
   assign issue        = ((state_ff == otrw_pkg::ST_SCAN) ||
                          (state_ff == otrw_pkg::ST_SHIFT)) && !scan_end;
   assign shift_dst    = pend_addr_ff - CntW'(1);
   assign go_scan      = !write_held_ff && !count_zero &&
                         ((cmd_ff == otrw_pkg::CMD_QUERY) ||
                          (cmd_ff == otrw_pkg::CMD_UNLOCK) ||
                          ((cmd_ff == otrw_pkg::CMD_LOCK) && (rd_ff || count_one)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         otrw_pkg::ST_IDLE: begin
            if (start) state_in = otrw_pkg::ST_DECODE;
         end
         otrw_pkg::ST_DECODE: begin
            state_in = go_scan ? otrw_pkg::ST_SCAN : otrw_pkg::ST_DONE;
         end
         otrw_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = (cmd_ff == otrw_pkg::CMD_UNLOCK) ? otrw_pkg::ST_SHIFT
                                                            : otrw_pkg::ST_DONE;
            end else if (scan_miss) begin
               state_in = otrw_pkg::ST_DONE;
            end
         end
         otrw_pkg::ST_SHIFT: begin
            if (scan_end) state_in = otrw_pkg::ST_DONE;
         end
         otrw_pkg::ST_DONE: begin
            if (out_free) state_in = otrw_pkg::ST_IDLE;
         end
         default: state_in = otrw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      rd_in         = rd_ff;
      write_held_in = write_held_ff;
      writer_id_in  = writer_id_ff;
      count_in      = count_ff;
      answer_in     = answer_ff;
      bad_in        = bad_ff;
      ram_rd_en     = issue;
      pend_in       = issue;
      pend_addr_in  = addr_ff;
      addr_in       = issue ? CntW'(addr_ff + 1'b1) : addr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = id_ff;

      unique case (state_ff)
         otrw_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in    = otrw_pkg::command_type'(command);
               id_in     = thread_id[IdW-1:0];
               rd_in     = read_only;
               answer_in = '0;
               bad_in    = 1'b0;
            end
         end
         otrw_pkg::ST_DECODE: begin
            addr_in = '0;
            pend_in = 1'b0;
            unique case (cmd_ff)
               otrw_pkg::CMD_QUERY: begin
                  if (write_held_ff) begin
                     answer_in = writer_match ? otrw_pkg::QRY_WR_MINE
                                              : otrw_pkg::QRY_WR_OTHER;
                  end else begin
                     answer_in = otrw_pkg::QRY_UNLOCKED;
                  end
               end
               otrw_pkg::CMD_LOCK: begin
                  if (rd_ff) begin
                     if (write_held_ff) begin
                        if (writer_match) begin
                           // demote owner to sole reader
                           ram_wr_en     = 1'b1;
                           count_in      = CntW'(1);
                           write_held_in = 1'b0;
                           answer_in     = otrw_pkg::LOCK_GRANTED;
                        end else begin
                           answer_in = otrw_pkg::LOCK_REFUSED;
                        end
                     end else if (count_zero) begin
                        ram_wr_en = 1'b1;
                        count_in  = CntW'(1);
                        answer_in = otrw_pkg::LOCK_GRANTED;
                     end
                  end else begin
                     if (count_zero) begin
                        if (!write_held_ff) begin
                           writer_id_in  = id_ff;
                           write_held_in = 1'b1;
                           answer_in     = otrw_pkg::LOCK_GRANTED;
                        end else begin
                           answer_in = writer_match ? otrw_pkg::LOCK_GRANTED
                                                    : otrw_pkg::LOCK_REFUSED;
                        end
                     end else begin
                        answer_in = otrw_pkg::LOCK_REFUSED;
                     end
                  end
               end
               otrw_pkg::CMD_UNLOCK: begin
                  if (write_held_ff) begin
                     if (writer_match) begin
                        write_held_in = 1'b0;
                        answer_in     = otrw_pkg::UNL_RELEASED;
                     end else begin
                        answer_in = otrw_pkg::UNL_WR_OTHER;
                     end
                  end else begin
                     answer_in = otrw_pkg::UNL_NOT_HELD;
                  end
               end
               default: begin
                  answer_in = '0;
                  bad_in    = 1'b1;
               end
            endcase
         end
         otrw_pkg::ST_SCAN: begin
            if (hit) begin
               unique case (cmd_ff)
                  otrw_pkg::CMD_QUERY: answer_in = otrw_pkg::QRY_RD_MINE;
                  otrw_pkg::CMD_LOCK: begin
                     if (!rd_ff) begin
                        // promote sole reader to owner
                        count_in      = '0;
                        writer_id_in  = id_ff;
                        write_held_in = 1'b1;
                     end
                     answer_in = otrw_pkg::LOCK_GRANTED;
                  end
                  otrw_pkg::CMD_UNLOCK: begin
                     answer_in = otrw_pkg::UNL_RELEASED;
                     addr_in   = CntW'(pend_addr_ff + 1'b1);
                     pend_in   = 1'b0;
                  end
                  default: answer_in = answer_ff;
               endcase
            end else if (scan_miss) begin
               unique case (cmd_ff)
                  otrw_pkg::CMD_QUERY: answer_in = otrw_pkg::QRY_RD_OTHERS;
                  otrw_pkg::CMD_LOCK: begin
                     if (rd_ff && !count_full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IdxW-1:0];
                        count_in    = CntW'(count_ff + 1'b1);
                        answer_in   = otrw_pkg::LOCK_GRANTED;
                     end else begin
                        answer_in = otrw_pkg::LOCK_REFUSED;
                     end
                  end
                  otrw_pkg::CMD_UNLOCK: answer_in = otrw_pkg::UNL_NOT_HELD;
                  default: answer_in = answer_ff;
               endcase
            end
         end
         otrw_pkg::ST_SHIFT: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = shift_dst[IdxW-1:0];
               ram_wr_data = ram_rd_data;
            end
            if (scan_end) begin
               count_in = CntW'(count_ff - 1'b1);
            end
         end
         otrw_pkg::ST_DONE: begin
            pend_in = 1'b0;
         end
         default: pend_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= otrw_pkg::ST_IDLE;
         write_held_ff <= 1'b0;
         writer_id_ff  <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_held_ff <= write_held_in;
         writer_id_ff  <= writer_id_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      rd_ff        <= rd_in;
      addr_ff      <= addr_in;
      pend_addr_ff <= pend_addr_in;
      answer_ff    <= answer_in;
      bad_ff       <= bad_in;
   end

   assign idle               = (state_ff == otrw_pkg::ST_IDLE);
   assign done               = (state_ff == otrw_pkg::ST_DONE);
   assign result.answer      = answer_ff;
   assign result.bad_command = bad_ff;

endmodule

// File: design/owner_tracking_rw_lock_unit.sv
// Top level of the owner-tracking reader-writer lock with its response register.
//
// Requests arrive on the req_ stream: req_tuser carries the command (query, lock,
// unlock; the fourth code is flagged as bad), req_tdata the thread ID in bits 7:0
// and the read-only flag in bit 8. Each request gives exactly one response on the
// rsp_ stream: the answer code in rsp_tdata[2:0] and the bad-command flag in
// rsp_tuser.
// Requests are handled one at a time; req_tready is low from acceptance until the
// response is loaded into the output register. A request that needs no scan of the
// reader list goes from decode straight to done; otherwise the list of N readers is
// scanned until a hit or its end, and a reader unlock scans up to the caller's entry
// and then moves the later entries down one place. Both loops run over the single
// read port of the reader ID store, one entry per cycle.
// Reset empties the lock (no writer, no readers) and drops any pending response.
// While rsp_tready is low the response holds in its register, and a finished
// request waits there, so no further request is taken until the response leaves.
module owner_tracking_rw_lock_unit #(
   parameter int unsigned MAX_READERS    = otrw_pkg::MAX_READERS_DEF,
   parameter int unsigned THREAD_ID_BITS = otrw_pkg::THREAD_ID_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [otrw_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // thread_id, read_only
   input  logic [1:0]                            req_tuser,  // command
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [otrw_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // answer
   output logic                                  rsp_tuser   // bad_command
);

   logic                 ctrl_idle;
   logic                 ctrl_done;
   otrw_pkg::result_type ctrl_result;
   logic                 out_free;
   logic                 load;

   logic                 rsp_valid_ff, rsp_valid_in;
   otrw_pkg::result_type rsp_result_ff;

   otrw_ctrl #(
      .MAX_READERS    (MAX_READERS),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && ctrl_idle),
      .command   (req_tuser),
      .thread_id (req_tdata[otrw_pkg::ID_FIELD_BITS-1:0]),
      .read_only (req_tdata[otrw_pkg::ID_FIELD_BITS]),
      .out_free  (out_free),
      .idle      (ctrl_idle),
      .done      (ctrl_done),
      .result    (ctrl_result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = ctrl_done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_result_ff <= ctrl_result;
      end
   end

   assign req_tready = ctrl_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(otrw_pkg::RSP_TDATA_BITS - otrw_pkg::ANSWER_BITS){1'b0}},
                        rsp_result_ff.answer};
   assign rsp_tuser  = rsp_result_ff.bad_command;

   a_bad_answer_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad command response carries a non-zero answer");

   a_answer_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= otrw_pkg::RSP_TDATA_BITS'(otrw_pkg::QRY_RD_OTHERS))
      else $error("answer code out of range");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in progress");

   a_load_when_busy : assert property (@(posedge clock) disable iff (reset)
      load |-> !req_tready)
      else $error("response loaded while sequencer idle");

endmodule
